[sv/ptwsp_pkg.sv]
package ptwsp_pkg;

    // Encoder count width taken from each count input and the integral clamp.
    localparam int COUNT_BITS     = 32;
    localparam int INTEGRAL_LIMIT = 1000;

    // Field and register widths.
    localparam int ANGLE_W  = 10;
    localparam int TICK_W   = 16;
    localparam int GAIN_W   = 20;
    localparam int PWM_W    = 8;
    localparam int STEP_W   = 4;
    localparam int TARGET_W = STEP_W + TICK_W;
    localparam int INT_W    = 11;
    localparam int FRAC_W   = 16;
    localparam int STATUS_W = 2;

    // Datapath widths derived from the count width.
    localparam int MAG_W    = COUNT_BITS;
    localparam int ERR_W    = COUNT_BITS + 1;
    localparam int DER_W    = COUNT_BITS + 2;
    localparam int CMP_W    = (MAG_W > TARGET_W) ? MAG_W : TARGET_W;
    localparam int ESAT_W   = 13;
    localparam int ISUM_W   = ESAT_W + 1;
    localparam int BPROD_W  = GAIN_W + TARGET_W;
    localparam int BASE_W   = BPROD_W - FRAC_W;
    localparam int KP_W     = GAIN_W + 1 + ERR_W;
    localparam int KI_W     = GAIN_W + 1 + INT_W;
    localparam int KD_W     = GAIN_W + 1 + DER_W;
    localparam int CORR_W   = KD_W + 2;
    localparam int SQ_W     = CORR_W + 1;

    // Configuration port.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register reset values.
    localparam logic [ANGLE_W-1:0] ANGLE_RST   = ANGLE_W'(45);
    localparam logic [TICK_W-1:0]  TICKS_RST   = TICK_W'(8420);
    localparam logic [GAIN_W-1:0]  GAIN_RST    = GAIN_W'(72090);
    localparam logic [GAIN_W-1:0]  KP_RST      = GAIN_W'(19661);
    localparam logic [GAIN_W-1:0]  KI_RST      = GAIN_W'(197);
    localparam logic [GAIN_W-1:0]  KD_RST      = GAIN_W'(7);
    localparam logic [PWM_W-1:0]   CEILING_RST = PWM_W'(200);
    localparam logic [PWM_W-1:0]   FLOOR_RST   = PWM_W'(150);

    typedef enum logic [2:0] {
        REG_ANGLE   = 3'd0,
        REG_TICKS   = 3'd1,
        REG_GAIN    = 3'd2,
        REG_KP      = 3'd3,
        REG_KI      = 3'd4,
        REG_KD      = 3'd5,
        REG_CEILING = 3'd6,
        REG_FLOOR   = 3'd7
    } t_reg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_TURNING = 2'd0,
        ST_REACHED = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    // Configuration as seen by the datapath, including derived values.
    typedef struct packed {
        logic                angle_ok;
        logic                angle_pos;
        logic [TARGET_W-1:0] target;
        logic [GAIN_W-1:0]   position_gain;
        logic [GAIN_W-1:0]   sync_kp;
        logic [GAIN_W-1:0]   sync_ki;
        logic [GAIN_W-1:0]   sync_kd;
        logic [PWM_W-1:0]    pwm_ceiling;
        logic [PWM_W-1:0]    pwm_floor;
    } t_cfg;

    // Per-item values handed from the tracking stages to the drive stages.
    typedef struct packed {
        t_status                   status;
        logic                      master_forward;
        logic [TARGET_W-1:0]       remaining;
        logic signed [ERR_W-1:0]   error;
        logic signed [INT_W-1:0]   integral;
        logic signed [DER_W-1:0]   deriv;
    } t_trk;

    // Number of 45-degree steps in an angle magnitude; zero when the
    // magnitude is zero, above 495 or not a multiple of 45.
    function automatic logic [STEP_W-1:0] angle_steps(input logic [ANGLE_W-1:0] mag);
        logic [STEP_W-1:0] steps;
        case (mag)
            ANGLE_W'(45):  steps = STEP_W'(1);
            ANGLE_W'(90):  steps = STEP_W'(2);
            ANGLE_W'(135): steps = STEP_W'(3);
            ANGLE_W'(180): steps = STEP_W'(4);
            ANGLE_W'(225): steps = STEP_W'(5);
            ANGLE_W'(270): steps = STEP_W'(6);
            ANGLE_W'(315): steps = STEP_W'(7);
            ANGLE_W'(360): steps = STEP_W'(8);
            ANGLE_W'(405): steps = STEP_W'(9);
            ANGLE_W'(450): steps = STEP_W'(10);
            ANGLE_W'(495): steps = STEP_W'(11);
            default:       steps = '0;
        endcase
        return steps;
    endfunction

endpackage

[sv/ptwsp_cfg.sv]
module ptwsp_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ptwsp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ptwsp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ptwsp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    output ptwsp_pkg::t_cfg                     o_cfg
);
    import ptwsp_pkg::*;

    logic [ANGLE_W-1:0]  r_angle;
    logic [TICK_W-1:0]   r_ticks;
    logic [GAIN_W-1:0]   r_gain;
    logic [GAIN_W-1:0]   r_kp;
    logic [GAIN_W-1:0]   r_ki;
    logic [GAIN_W-1:0]   r_kd;
    logic [PWM_W-1:0]    r_ceiling;
    logic [PWM_W-1:0]    r_floor;

    logic                r_angle_ok;
    logic                r_angle_pos;
    logic [TARGET_W-1:0] r_target;

    logic                wr_en;
    t_reg_idx            reg_idx;
    logic [ANGLE_W-1:0]  angle_mag;
    logic [STEP_W-1:0]   steps;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);

    // Register writes on the access phase of a write transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle   <= ANGLE_RST;
            r_ticks   <= TICKS_RST;
            r_gain    <= GAIN_RST;
            r_kp      <= KP_RST;
            r_ki      <= KI_RST;
            r_kd      <= KD_RST;
            r_ceiling <= CEILING_RST;
            r_floor   <= FLOOR_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ANGLE:   r_angle   <= pwdata[ANGLE_W-1:0];
                REG_TICKS:   r_ticks   <= pwdata[TICK_W-1:0];
                REG_GAIN:    r_gain    <= pwdata[GAIN_W-1:0];
                REG_KP:      r_kp      <= pwdata[GAIN_W-1:0];
                REG_KI:      r_ki      <= pwdata[GAIN_W-1:0];
                REG_KD:      r_kd      <= pwdata[GAIN_W-1:0];
                REG_CEILING: r_ceiling <= pwdata[PWM_W-1:0];
                REG_FLOOR:   r_floor   <= pwdata[PWM_W-1:0];
                default:     r_floor   <= r_floor;
            endcase
        end
    end

    // Read data mux; the angle reads back sign extended.
    always_comb begin
        case (reg_idx)
            REG_ANGLE:   prdata = {{(APB_DATA_W-ANGLE_W){r_angle[ANGLE_W-1]}}, r_angle};
            REG_TICKS:   prdata = APB_DATA_W'(r_ticks);
            REG_GAIN:    prdata = APB_DATA_W'(r_gain);
            REG_KP:      prdata = APB_DATA_W'(r_kp);
            REG_KI:      prdata = APB_DATA_W'(r_ki);
            REG_KD:      prdata = APB_DATA_W'(r_kd);
            REG_CEILING: prdata = APB_DATA_W'(r_ceiling);
            REG_FLOOR:   prdata = APB_DATA_W'(r_floor);
            default:     prdata = '0;
        endcase
    end

    // Angle magnitude, step count and turn target.
    assign angle_mag = r_angle[ANGLE_W-1] ? (~r_angle + ANGLE_W'(1)) : r_angle;
    assign steps     = angle_steps(angle_mag);

    always_ff @(posedge i_clk) begin
        r_angle_ok  <= (steps != '0);
        r_angle_pos <= !r_angle[ANGLE_W-1] && (r_angle != '0);
        r_target    <= TARGET_W'(steps) * TARGET_W'(r_ticks);
    end

    always_comb begin
        o_cfg.angle_ok      = r_angle_ok;
        o_cfg.angle_pos     = r_angle_pos;
        o_cfg.target        = r_target;
        o_cfg.position_gain = r_gain;
        o_cfg.sync_kp       = r_kp;
        o_cfg.sync_ki       = r_ki;
        o_cfg.sync_kd       = r_kd;
        o_cfg.pwm_ceiling   = r_ceiling;
        o_cfg.pwm_floor     = r_floor;
    end

endmodule

[sv/ptwsp_track.sv]
module ptwsp_track (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ptwsp_pkg::t_cfg                i_cfg,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_start_move,
    input  logic signed [31:0]             i_master_count,
    input  logic signed [31:0]             i_slave_count,
    output logic                           o_valid,
    input  logic                           i_stall,
    output ptwsp_pkg::t_trk                o_trk
);
    import ptwsp_pkg::*;

    localparam logic signed [ISUM_W-1:0] ILIM_POS = ISUM_W'(INTEGRAL_LIMIT);
    localparam logic signed [ISUM_W-1:0] ILIM_NEG = -ISUM_W'(INTEGRAL_LIMIT);
    localparam logic signed [ESAT_W-1:0] ESAT_MAX = {1'b0, {(ESAT_W-1){1'b1}}};
    localparam logic signed [ESAT_W-1:0] ESAT_MIN = {1'b1, {(ESAT_W-1){1'b0}}};

    // Stage valids and flow control.
    logic r_v0, r_v1, r_v2;
    logic take0, take1, take2, adv1;

    // Input register.
    logic                  r_start0;
    logic [COUNT_BITS-1:0] r_mcnt0;
    logic [COUNT_BITS-1:0] r_scnt0;

    // Magnitude register.
    logic             r_start1;
    logic [MAG_W-1:0] r_mmag1;
    logic [MAG_W-1:0] r_smag1;

    // Turn state.
    logic                    r_done;
    logic signed [INT_W-1:0] r_integral;
    logic signed [ERR_W-1:0] r_last_error;
    logic                    n_done;
    logic signed [INT_W-1:0] n_integral;
    logic signed [ERR_W-1:0] n_last_error;

    // Stage logic.
    logic [MAG_W-1:0]        mmag, smag;
    logic signed [ERR_W-1:0] error;
    logic [CMP_W-1:0]        m_x, tgt_x, rem_full;
    logic                    reached;
    logic                    eff_done;
    logic signed [INT_W-1:0] eff_int;
    logic signed [ERR_W-1:0] eff_last;
    logic                    sat_hi, sat_lo;
    logic signed [ESAT_W-1:0] esat;
    logic signed [ISUM_W-1:0] isum;
    logic signed [INT_W-1:0] int_upd;
    logic signed [DER_W-1:0] deriv;
    t_trk                    n_trk;
    t_trk                    r_trk2;

    assign take2   = !r_v2 || !i_stall;
    assign take1   = !r_v1 || take2;
    assign take0   = !r_v0 || take1;
    assign adv1    = r_v1 && take2;
    assign o_stall = !take0;
    assign o_valid = r_v2;
    assign o_trk   = r_trk2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (take0) r_v0 <= i_valid;
            if (take1) r_v1 <= r_v0;
            if (take2) r_v2 <= r_v1;
        end
    end

    // Input transfer: keep the low count bits of each encoder.
    always_ff @(posedge i_clk) begin
        if (take0 && i_valid) begin
            r_start0 <= i_start_move;
            r_mcnt0  <= i_master_count[COUNT_BITS-1:0];
            r_scnt0  <= i_slave_count[COUNT_BITS-1:0];
        end
    end

    // Stage A: absolute encoder counts.
    assign mmag = r_mcnt0[COUNT_BITS-1] ? (~r_mcnt0 + MAG_W'(1)) : r_mcnt0;
    assign smag = r_scnt0[COUNT_BITS-1] ? (~r_scnt0 + MAG_W'(1)) : r_scnt0;

    always_ff @(posedge i_clk) begin
        if (take1 && r_v0) begin
            r_start1 <= r_start0;
            r_mmag1  <= mmag;
            r_smag1  <= smag;
        end
    end

    // Stage B: target compare, sync error, integral and derivative.
    assign error    = $signed({1'b0, r_smag1}) - $signed({1'b0, r_mmag1});
    assign m_x      = CMP_W'(r_mmag1);
    assign tgt_x    = CMP_W'(i_cfg.target);
    assign reached  = (m_x >= tgt_x);
    assign rem_full = tgt_x - m_x;

    // A new turn clears the state before this tick is used.
    assign eff_done = r_start1 ? 1'b0 : r_done;
    assign eff_int  = r_start1 ? '0 : r_integral;
    assign eff_last = r_start1 ? '0 : r_last_error;

    // The error is saturated first; the integral clamp hides the difference.
    assign sat_hi = !error[ERR_W-1] && (|error[ERR_W-2:ESAT_W-1]);
    assign sat_lo = error[ERR_W-1] && !(&error[ERR_W-2:ESAT_W-1]);

    always_comb begin
        if (sat_hi) begin
            esat = ESAT_MAX;
        end else if (sat_lo) begin
            esat = ESAT_MIN;
        end else begin
            esat = error[ESAT_W-1:0];
        end
        isum = ISUM_W'(eff_int) + ISUM_W'(esat);
        if (isum > ILIM_POS) begin
            int_upd = INT_W'(ILIM_POS);
        end else if (isum < ILIM_NEG) begin
            int_upd = INT_W'(ILIM_NEG);
        end else begin
            int_upd = isum[INT_W-1:0];
        end
    end

    assign deriv = DER_W'(error) - DER_W'(eff_last);

    // Decide the status and the next turn state.
    always_comb begin
        n_done       = eff_done;
        n_integral   = eff_int;
        n_last_error = eff_last;
        n_trk.master_forward = i_cfg.angle_pos;
        n_trk.remaining      = rem_full[TARGET_W-1:0];
        n_trk.error          = error;
        n_trk.integral       = int_upd;
        n_trk.deriv          = deriv;
        if (!i_cfg.angle_ok) begin
            n_trk.status = ST_INVALID;
        end else if (eff_done || reached) begin
            n_trk.status = ST_REACHED;
            n_done       = 1'b1;
        end else begin
            n_trk.status = ST_TURNING;
            n_integral   = int_upd;
            n_last_error = error;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done       <= 1'b0;
            r_integral   <= '0;
            r_last_error <= '0;
        end else if (adv1) begin
            r_done       <= n_done;
            r_integral   <= n_integral;
            r_last_error <= n_last_error;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_trk2 <= n_trk;
        end
    end

endmodule

[sv/ptwsp_drive.sv]
module ptwsp_drive (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ptwsp_pkg::t_cfg                i_cfg,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  ptwsp_pkg::t_trk                i_trk,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [ptwsp_pkg::PWM_W-1:0]    o_lead_pwm,
    output logic [ptwsp_pkg::PWM_W-1:0]    o_follow_pwm,
    output logic                           o_master_forward,
    output logic                           o_slave_forward,
    output logic [ptwsp_pkg::STATUS_W-1:0] o_status
);
    import ptwsp_pkg::*;

    // Stage valids and flow control.
    logic r_v3, r_v4, r_vo;
    logic take3, take4, take_o;

    // Product register.
    t_status                  r_status3;
    logic                     r_fwd3;
    logic [BPROD_W-1:0]       r_bprod3;
    logic signed [KP_W-1:0]   r_kp_p3;
    logic signed [KI_W-1:0]   r_ki_p3;
    logic signed [KD_W-1:0]   r_kd_p3;

    // Correction register.
    t_status                  r_status4;
    logic                     r_fwd4;
    logic [PWM_W-1:0]         r_master4;
    logic signed [CORR_W-1:0] r_corr4;

    // Result register.
    logic [PWM_W-1:0]         r_mpwm;
    logic [PWM_W-1:0]         r_spwm;
    logic                     r_mfwd;
    t_status                  r_status;

    logic [BASE_W-1:0]        base;
    logic [PWM_W-1:0]         base_c, base_f, master;
    logic signed [CORR_W-1:0] n_corr;
    logic signed [SQ_W-1:0]   slave_q, ceil_q, floor_q;
    logic [PWM_W-1:0]         spwm;
    logic [PWM_W-1:0]         n_mpwm, n_spwm;

    assign take_o  = !r_vo || !i_stall;
    assign take4   = !r_v4 || take_o;
    assign take3   = !r_v3 || take4;
    assign o_stall = !take3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (take3)  r_v3 <= i_valid;
            if (take4)  r_v4 <= r_v3;
            if (take_o) r_vo <= r_v4;
        end
    end

    // Stage C: position and PID products.
    always_ff @(posedge i_clk) begin
        if (take3 && i_valid) begin
            r_status3 <= i_trk.status;
            r_fwd3    <= i_trk.master_forward;
            r_bprod3  <= BPROD_W'(i_cfg.position_gain) * BPROD_W'(i_trk.remaining);
            r_kp_p3   <= $signed({1'b0, i_cfg.sync_kp}) * i_trk.error;
            r_ki_p3   <= $signed({1'b0, i_cfg.sync_ki}) * i_trk.integral;
            r_kd_p3   <= $signed({1'b0, i_cfg.sync_kd}) * i_trk.deriv;
        end
    end

    // Stage D: master PWM limits, applied in the order ceiling, floor, both.
    assign base = r_bprod3[BPROD_W-1:FRAC_W];

    always_comb begin
        if (base > BASE_W'(i_cfg.pwm_ceiling)) begin
            base_c = i_cfg.pwm_ceiling;
        end else begin
            base_c = base[PWM_W-1:0];
        end
        base_f = (base_c < i_cfg.pwm_floor) ? i_cfg.pwm_floor : base_c;
        if (base_f > i_cfg.pwm_ceiling) begin
            master = i_cfg.pwm_ceiling;
        end else if (base_f < i_cfg.pwm_floor) begin
            master = i_cfg.pwm_floor;
        end else begin
            master = base_f;
        end
    end

    assign n_corr = CORR_W'(r_kp_p3) + CORR_W'(r_ki_p3) + CORR_W'(r_kd_p3);

    always_ff @(posedge i_clk) begin
        if (take4 && r_v3) begin
            r_status4 <= r_status3;
            r_fwd4    <= r_fwd3;
            r_master4 <= master;
            r_corr4   <= n_corr;
        end
    end

    // Stage E: slave PWM in Q16, limited to the ceiling and floor; both PWMs are zero unless turning.
    assign slave_q = $signed({{(SQ_W-PWM_W-FRAC_W){1'b0}}, r_master4, {FRAC_W{1'b0}}})
                     - SQ_W'(r_corr4);
    assign ceil_q  = $signed({{(SQ_W-PWM_W-FRAC_W){1'b0}}, i_cfg.pwm_ceiling, {FRAC_W{1'b0}}});
    assign floor_q = $signed({{(SQ_W-PWM_W-FRAC_W){1'b0}}, i_cfg.pwm_floor, {FRAC_W{1'b0}}});

    always_comb begin
        if (slave_q > ceil_q) begin
            spwm = i_cfg.pwm_ceiling;
        end else if (slave_q < floor_q) begin
            spwm = i_cfg.pwm_floor;
        end else begin
            spwm = slave_q[FRAC_W+PWM_W-1:FRAC_W];
        end
        if (r_status4 == ST_TURNING) begin
            n_mpwm = r_master4;
            n_spwm = spwm;
        end else begin
            n_mpwm = '0;
            n_spwm = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_o && r_v4) begin
            r_mpwm   <= n_mpwm;
            r_spwm   <= n_spwm;
            r_mfwd   <= r_fwd4;
            r_status <= r_status4;
        end
    end

    assign o_valid          = r_vo;
    assign o_lead_pwm       = r_mpwm;
    assign o_follow_pwm     = r_spwm;
    assign o_master_forward = r_mfwd;
    assign o_slave_forward  = !r_mfwd;
    assign o_status         = r_status;

endmodule

[sv/point_turn_wheel_sync_pid.sv]
// Point-turn wheel synchronization controller. Each input transfer is one
// control tick carrying both encoder counts; each tick yields exactly one
// output transfer with both PWM compare values, the wheel directions and a
// status (turning, target reached, invalid angle). The right wheel is driven
// toward a target of (|angle| / 45) * ticks_per_eighth_turn ticks and the left
// wheel follows through a PID correction on the count difference. A tick with
// start_move set clears the integral, the previous error and the done latch.
// The datapath is a six-register pipeline (input, magnitudes, state update,
// products, correction, result); the input register loads on the edge that
// takes the tick, and a new tick is taken every cycle unless the output is
// stalled; the loop on the integral, previous error and done latch closes
// within the state-update stage. Configuration registers sit at byte address
// 4*i and must be written only while no tick is in flight.
module point_turn_wheel_sync_pid (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ptwsp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ptwsp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ptwsp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_start_move,
    input  logic signed [31:0]                  i_master_count,
    input  logic signed [31:0]                  i_slave_count,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [ptwsp_pkg::PWM_W-1:0]         o_lead_pwm,
    output logic [ptwsp_pkg::PWM_W-1:0]         o_follow_pwm,
    output logic                                o_master_forward,
    output logic                                o_slave_forward,
    output logic [ptwsp_pkg::STATUS_W-1:0]      o_status
);
    import ptwsp_pkg::*;

    t_cfg cfg;
    t_trk trk;
    logic trk_valid;
    logic trk_stall;

    // Configuration registers and derived turn target.
    ptwsp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Encoder magnitudes, sync error and turn state.
    ptwsp_track u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_start_move   (i_start_move),
        .i_master_count (i_master_count),
        .i_slave_count  (i_slave_count),
        .o_valid        (trk_valid),
        .i_stall        (trk_stall),
        .o_trk          (trk)
    );

    // Gains, correction and PWM limits.
    ptwsp_drive u_drive (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_valid          (trk_valid),
        .o_stall          (trk_stall),
        .i_trk            (trk),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_lead_pwm       (o_lead_pwm),
        .o_follow_pwm     (o_follow_pwm),
        .o_master_forward (o_master_forward),
        .o_slave_forward  (o_slave_forward),
        .o_status         (o_status)
    );

endmodule
